/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file i2pc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define AST_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/i2pc_pkg.sv */
package i2pc_pkg;

    localparam int IDX_W   = 48;             // candidate index
    localparam int CS_W    = 6;              // charset size register
    localparam int ML_W    = 4;              // max length register
    localparam int CH_W    = 7;              // character code
    localparam int CFG_W   = 6;              // config data, widest register
    localparam int NIB_W   = 4;              // index bits consumed per cell per cycle
    localparam int NIB_CNT = IDX_W / NIB_W;  // transfers to stream one index
    localparam int NC_W    = $clog2(NIB_CNT);

    localparam logic CFG_CHARSET = 1'b0;
    localparam logic CFG_MAXLEN  = 1'b1;

    localparam logic [CS_W-1:0] CS_RESET = 6'd52;
    localparam logic [ML_W-1:0] ML_RESET = 4'd8;
    localparam logic [CS_W-1:0] CS_MIN   = 6'd2;
    localparam logic [CS_W-1:0] LETTERS  = 6'd26;
    localparam logic [CS_W-1:0] TBL_SIZE = 6'd52;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEN  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // one transfer between neighboring divider cells
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [NIB_W-1:0] data;
    } t_link;

    // alphabet: a..z then A..Z, zero past the table
    function automatic logic [CH_W-1:0] alpha_char(input logic [CS_W-1:0] d);
        logic [CH_W-1:0] ch;
        if (d < LETTERS) begin
            ch = 7'h61 + {1'b0, d};
        end else if (d < TBL_SIZE) begin
            ch = 7'h41 + {1'b0, d - LETTERS};
        end else begin
            ch = '0;
        end
        return ch;
    endfunction

endpackage

/* rtl/core/i2pc_in_if.sv */
interface i2pc_in_if import i2pc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] cand_index;

    modport source (output valid, output cand_index, input ready);
    modport sink (input valid, input cand_index, output ready);
endinterface

/* rtl/core/i2pc_out_if.sv */
interface i2pc_out_if import i2pc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] char_code;
    logic            last_char;
    logic            out_of_range;

    modport source (output valid, output char_code, output last_char,
                    output out_of_range, input ready);
    modport sink (input valid, input char_code, input last_char,
                  input out_of_range, output ready);
endinterface

/* rtl/core/i2pc_cell.sv */
// One divide-by-charset cell: long division, NIB_W quotient bits per cycle.
// Holds the running remainder, which ends as one base-c digit.
module i2pc_cell import i2pc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic [CS_W-1:0] i_cs,
    input  t_link           i_link,
    output t_link           o_link,
    output logic [CS_W-1:0] o_digit
);

    logic [CS_W-1:0]  r_rem;
    logic [CS_W-1:0]  n_rem;
    logic [NIB_W-1:0] n_quo;
    t_link            r_link;

    always_comb begin
        logic [CS_W:0]   t;
        logic [CS_W-1:0] r;
        r     = r_rem;
        n_quo = '0;
        for (int b = NIB_W - 1; b >= 0; b--) begin
            t = {r, i_link.data[b]};
            if (t >= {1'b0, i_cs}) begin
                t        = t - {1'b0, i_cs};
                n_quo[b] = 1'b1;
            end
            r = t[CS_W-1:0];
        end
        n_rem = r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link.valid <= i_link.valid;
            r_link.last  <= i_link.last;
            r_link.data  <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_rem <= '0;
        end else if (i_link.valid) begin
            r_rem <= n_rem;
        end
    end

    assign o_link  = r_link;
    assign o_digit = r_rem;

endmodule

/* rtl/core/index_to_password_candidate_top.sv */
// An accepted index passes a length search, the divider chain and the emit step; an
// out-of-range index skips the divider chain and gives a single zero character. A new index
// is taken only once the last character of the previous candidate is in the output
// register; characters leave one per cycle while the receiver is ready. The offset
// enters the divider chain as 12 transfers of NIB_W bits. Reset (synchronous, active
// low) gives 52 symbols, max length 8, idle control and no pending result.
module index_to_password_candidate_top import i2pc_pkg::*; #(
    parameter int MAX_LEN       = 8,
    parameter int ALPHABET_SIZE = 52
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    i2pc_in_if.sink           i_in,
    i2pc_out_if.source        o_out
);

    localparam int LW = $clog2(MAX_LEN + 1);              // holds 1..MAX_LEN
    localparam int DW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1; // digit position

    // ---------------- configuration ----------------
    logic [CS_W-1:0] r_cs;
    logic [ML_W-1:0] r_ml;
    logic [CS_W-1:0] eff_cs;
    logic [LW-1:0]   eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs <= CS_RESET;
            r_ml <= ML_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHARSET: r_cs <= i_cfg_data;
                CFG_MAXLEN:  r_ml <= i_cfg_data[ML_W-1:0];
                default:     ;
            endcase
        end
    end

    // clamp charset to [2, ALPHABET_SIZE] and length to [1, MAX_LEN]
    always_comb begin
        if (r_cs < CS_MIN) begin
            eff_cs = CS_MIN;
        end else if ({1'b0, r_cs} > (CS_W + 1)'(ALPHABET_SIZE)) begin
            eff_cs = CS_W'(ALPHABET_SIZE);
        end else begin
            eff_cs = r_cs;
        end
        if (r_ml == '0) begin
            eff_len = LW'(1);
        end else if (r_ml > ML_W'(MAX_LEN)) begin
            eff_len = LW'(MAX_LEN);
        end else begin
            eff_len = LW'(r_ml);
        end
    end

    // ---------------- sequencing state ----------------
    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_prev;     // candidates of all shorter lengths
    logic [IDX_W-1:0] r_block;    // charset^k
    logic [LW-1:0]    r_k;
    logic [LW-1:0]    r_len;
    logic             r_oor;
    logic [IDX_W-1:0] r_shift;    // offset, streamed MSB first
    logic [NC_W-1:0]  r_ncnt;
    logic             r_feed;
    logic [DW-1:0]    r_pos;

    // output register
    logic             r_ov;
    logic [CH_W-1:0]  r_char;
    logic             r_last;
    logic             r_oorf;

    logic [IDX_W:0]        n_sum;
    logic                  n_hit;
    logic [IDX_W+CS_W-1:0] n_prod;
    logic                  n_clr;
    logic                  in_fire;
    logic                  out_free;
    logic                  feed_last;
    logic                  chain_done;
    logic [CS_W-1:0]       dsel;

    t_link           link  [MAX_LEN+1];
    logic [CS_W-1:0] digit [MAX_LEN];

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_ov || o_out.ready;

    // length search: one block size per cycle, block*c registered for the next step
    assign n_sum  = {1'b0, r_prev} + {1'b0, r_block};
    assign n_hit  = {1'b0, r_idx} < n_sum;
    assign n_prod = r_block * eff_cs;
    assign n_clr  = (r_state == S_LEN) && n_hit;

    assign feed_last  = (r_ncnt == NC_W'(NIB_CNT - 1));
    assign chain_done = link[MAX_LEN].valid && link[MAX_LEN].last;

    // ---------------- divider chain ----------------
    // cell j ends holding digit j (weight charset^j) of the offset
    always_comb begin
        link[0].valid = r_feed;
        link[0].last  = feed_last;
        link[0].data  = r_shift[IDX_W-1 -: NIB_W];
    end

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        i2pc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (n_clr),
            .i_cs    (eff_cs),
            .i_link  (link[j]),
            .o_link  (link[j+1]),
            .o_digit (digit[j])
        );
    end

    assign dsel = digit[r_pos];

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_feed  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (n_hit) begin
                        r_state <= S_DIV;
                        r_feed  <= 1'b1;
                    end else if (r_k == eff_len) begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (r_feed && feed_last) begin
                        r_feed <= 1'b0;
                    end
                    if (chain_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_oor || r_pos == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output valid: loaded from the emit step, cleared once the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_idx   <= i_in.cand_index;
                    r_prev  <= '0;
                    r_block <= IDX_W'(eff_cs);
                    r_k     <= LW'(1);
                    r_oor   <= 1'b0;
                end
            end
            S_LEN: begin
                if (n_hit) begin
                    r_len   <= r_k;
                    r_shift <= r_idx - r_prev;
                    r_ncnt  <= '0;
                end else if (r_k == eff_len) begin
                    r_oor   <= 1'b1;
                end else begin
                    r_prev  <= n_sum[IDX_W-1:0];
                    r_block <= n_prod[IDX_W-1:0];
                    r_k     <= LW'(r_k + LW'(1));
                end
            end
            S_DIV: begin
                if (r_feed) begin
                    r_shift <= r_shift << NIB_W;
                    r_ncnt  <= NC_W'(r_ncnt + NC_W'(1));
                end
                if (chain_done) begin
                    r_pos <= DW'(r_len - LW'(1));
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_char <= r_oor ? '0 : alpha_char(dsel);
                    r_last <= r_oor || (r_pos == '0);
                    r_oorf <= r_oor;
                    r_pos  <= DW'(r_pos - DW'(1));
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.char_code    = r_char;
    assign o_out.last_char    = r_last;
    assign o_out.out_of_range = r_oorf;

endmodule

/* rtl/core/i2pc_checker.sv */
`include "assert_macros.svh"

module i2pc_checker import i2pc_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [CH_W-1:0] i_char_code,
    input logic            i_last_char,
    input logic            i_out_of_range
);

    // an out-of-range result is a lone zero character
    `AST_IMPLY(a_oor_form, i_clk, i_rst_n, i_out_valid && i_out_of_range, i_char_code == '0 && i_last_char)

    // one candidate at a time: input closes right after a transaction
    `AST_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // a stalled result holds its payload
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_char_code) && $stable(i_last_char))

    // nothing pending coming out of reset
    `AST_NEXT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind index_to_password_candidate_top i2pc_checker u_i2pc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_char_code    (o_out.char_code),
    .i_last_char    (o_out.last_char),
    .i_out_of_range (o_out.out_of_range)
);
